[rtl/core/trcf_pkg.sv]
// Shared types, command codes and arithmetic helpers for the rope chain force core.
package trcf_pkg;

	localparam int SQRT_STEPS = 34;
	localparam int DIV_STEPS  = 31;
	localparam logic [30:0] TMAX = 31'h7FFF_FFFF;

	localparam logic [1:0] REG_STIFFNESS    = 2'd0;
	localparam logic [1:0] REG_DAMPING      = 2'd1;
	localparam logic [1:0] REG_REST_LENGTH  = 2'd2;
	localparam logic [1:0] REG_MIN_DISTANCE = 2'd3;

	localparam logic [4:0] OP_NONE  = 5'd0;
	localparam logic [4:0] OP_LOAD  = 5'd1;
	localparam logic [4:0] OP_FIRST = 5'd2;
	localparam logic [4:0] OP_MSQ   = 5'd3;
	localparam logic [4:0] OP_ASQ   = 5'd4;
	localparam logic [4:0] OP_SQI   = 5'd5;
	localparam logic [4:0] OP_SQS   = 5'd6;
	localparam logic [4:0] OP_DVI   = 5'd7;
	localparam logic [4:0] OP_DVS   = 5'd8;
	localparam logic [4:0] OP_MRT   = 5'd9;
	localparam logic [4:0] OP_ART   = 5'd10;
	localparam logic [4:0] OP_MK    = 5'd11;
	localparam logic [4:0] OP_AK    = 5'd12;
	localparam logic [4:0] OP_MC    = 5'd13;
	localparam logic [4:0] OP_AC    = 5'd14;
	localparam logic [4:0] OP_MF    = 5'd15;
	localparam logic [4:0] OP_AF    = 5'd16;
	localparam logic [4:0] OP_OUT1  = 5'd17;
	localparam logic [4:0] OP_OUT2  = 5'd18;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] lane;
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic last;
	} sts_t;

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? (33'd0 - v) : v;
	endfunction

	// floor(p / 2^16) clipped to TMAX
	function automatic logic [30:0] sat_q16(input logic [67:0] p);
		logic [51:0] s;
		s = p[67:16];
		return (s > {21'd0, TMAX}) ? TMAX : s[30:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31])
			r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[rtl/core/trcf_ctrl.sv]
// Sequencer for the rope chain force core: handshakes, step order and loop counts.
module trcf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  trcf_pkg::sts_t      sts,
	output trcf_pkg::cmd_t      cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_FIRST = 5'd1;
	localparam logic [4:0] S_MSQ   = 5'd2;
	localparam logic [4:0] S_ASQ   = 5'd3;
	localparam logic [4:0] S_SQI   = 5'd4;
	localparam logic [4:0] S_SQS   = 5'd5;
	localparam logic [4:0] S_DVI   = 5'd6;
	localparam logic [4:0] S_DVS   = 5'd7;
	localparam logic [4:0] S_MRT   = 5'd8;
	localparam logic [4:0] S_ART   = 5'd9;
	localparam logic [4:0] S_MK    = 5'd10;
	localparam logic [4:0] S_AK    = 5'd11;
	localparam logic [4:0] S_MC    = 5'd12;
	localparam logic [4:0] S_AC    = 5'd13;
	localparam logic [4:0] S_MF    = 5'd14;
	localparam logic [4:0] S_AF    = 5'd15;
	localparam logic [4:0] S_OUT1  = 5'd16;
	localparam logic [4:0] S_OUT2  = 5'd17;

	localparam logic [5:0] SQ_LAST = 6'(trcf_pkg::SQRT_STEPS - 1);
	localparam logic [5:0] DV_LAST = 6'(trcf_pkg::DIV_STEPS - 1);

	logic [4:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [1:0] lane_q, lane_d;
	logic       out_valid_q;
	logic       out_load;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		lane_d   = lane_q;
		cmd.op   = trcf_pkg::OP_NONE;
		cmd.lane = lane_q;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = trcf_pkg::OP_LOAD;
					lane_d  = 2'd0;
					state_d = sts.have_prev ? S_MSQ : S_FIRST;
				end
			end
			S_FIRST: begin
				if (!sts.last || out_free) begin
					cmd.op   = trcf_pkg::OP_FIRST;
					out_load = sts.last;
					state_d  = S_IDLE;
				end
			end
			S_MSQ: begin
				cmd.op  = trcf_pkg::OP_MSQ;
				state_d = S_ASQ;
			end
			S_ASQ: begin
				cmd.op = trcf_pkg::OP_ASQ;
				if (lane_q == 2'd2) begin
					lane_d  = 2'd0;
					state_d = S_SQI;
				end else begin
					lane_d  = lane_q + 2'd1;
					state_d = S_MSQ;
				end
			end
			S_SQI: begin
				cmd.op  = trcf_pkg::OP_SQI;
				cnt_d   = 6'd0;
				state_d = S_SQS;
			end
			S_SQS: begin
				cmd.op = trcf_pkg::OP_SQS;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == SQ_LAST)
					state_d = S_DVI;
			end
			S_DVI: begin
				cmd.op  = trcf_pkg::OP_DVI;
				cnt_d   = 6'd0;
				state_d = S_DVS;
			end
			S_DVS: begin
				cmd.op = trcf_pkg::OP_DVS;
				cnt_d  = cnt_q + 6'd1;
				if (cnt_q == DV_LAST) begin
					lane_d  = 2'd0;
					state_d = S_MRT;
				end
			end
			S_MRT: begin
				cmd.op  = trcf_pkg::OP_MRT;
				state_d = S_ART;
			end
			S_ART: begin
				cmd.op = trcf_pkg::OP_ART;
				if (lane_q == 2'd2) begin
					lane_d  = 2'd0;
					state_d = S_MK;
				end else begin
					lane_d  = lane_q + 2'd1;
					state_d = S_MRT;
				end
			end
			S_MK: begin
				cmd.op  = trcf_pkg::OP_MK;
				state_d = S_AK;
			end
			S_AK: begin
				cmd.op  = trcf_pkg::OP_AK;
				state_d = S_MC;
			end
			S_MC: begin
				cmd.op  = trcf_pkg::OP_MC;
				state_d = S_AC;
			end
			S_AC: begin
				cmd.op  = trcf_pkg::OP_AC;
				lane_d  = 2'd0;
				state_d = S_MF;
			end
			S_MF: begin
				cmd.op  = trcf_pkg::OP_MF;
				state_d = S_AF;
			end
			S_AF: begin
				cmd.op = trcf_pkg::OP_AF;
				if (lane_q == 2'd2) begin
					lane_d  = 2'd0;
					state_d = S_OUT1;
				end else begin
					lane_d  = lane_q + 2'd1;
					state_d = S_MF;
				end
			end
			S_OUT1: begin
				if (out_free) begin
					cmd.op   = trcf_pkg::OP_OUT1;
					out_load = 1'b1;
					state_d  = sts.last ? S_OUT2 : S_IDLE;
				end
			end
			S_OUT2: begin
				if (out_free) begin
					cmd.op   = trcf_pkg::OP_OUT2;
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 6'd0;
			lane_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lane_q  <= lane_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/trcf_dp.sv]
// Datapath: config registers, chain state, shared multiplier, square root and divider lanes.
module trcf_dp #(
	parameter int MAX_NODES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  trcf_pkg::cmd_t      cmd,
	output trcf_pkg::sts_t      sts,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic signed [31:0]  vel_z,
	input  logic                last_node,
	output logic signed [31:0]  force_x,
	output logic signed [31:0]  force_y,
	output logic signed [31:0]  force_z,
	output logic [30:0]         segment_tension,
	output logic [5:0]          node_index,
	output logic                chain_done
);

	localparam int CW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam logic [CW-1:0] CNT_TOP = CW'(MAX_NODES - 1);

	logic [31:0] stiff_q, damp_q;
	logic [30:0] rest_q, mind_q;
	logic        have_prev_q;
	logic [CW-1:0] cnt_q;

	logic [31:0] pos_q [3];
	logic [31:0] vel_q [3];
	logic        last_q;
	logic [31:0] prev_pos_q [3];
	logic [31:0] prev_vel_q [3];
	logic [31:0] carried_q [3];
	logic [32:0] d_q [3];
	logic [32:0] dv_q [3];
	logic [67:0] p_q;
	logic [65:0] sumsq_q;
	logic [67:0] rad_q;
	logic [33:0] root_q;
	logic [35:0] rem_q;
	logic        act_q;
	logic [34:0] dr_q [3];
	logic        nb_q [3];
	logic [30:0] quo_q [3];
	logic signed [35:0] rate_q;
	logic [30:0] ten_q;
	logic        sg_q;
	logic [31:0] f_q [3];

	logic [32:0] mul_a;
	logic [34:0] mul_b;
	logic [32:0] d_mag, dv_mag;
	logic [33:0] stretch;
	logic [CW-1:0] lower_cnt;
	logic [CW+5:0] cnt_ext, low_ext;
	logic [37:0] sq_rn, sq_trial, sq_diff;
	logic [31:0] ten_sum;
	logic [30:0] ten_sat;
	logic [35:0] rt_term;
	logic [31:0] f_mag;
	logic [31:0] in_pos [3];
	logic [31:0] in_vel [3];

	assign in_pos[0] = pos_x;
	assign in_pos[1] = pos_y;
	assign in_pos[2] = pos_z;
	assign in_vel[0] = vel_x;
	assign in_vel[1] = vel_y;
	assign in_vel[2] = vel_z;

	assign sts.have_prev = have_prev_q;
	assign sts.last      = last_q;

	assign d_mag     = trcf_pkg::mag33(d_q[cmd.lane]);
	assign dv_mag    = trcf_pkg::mag33(dv_q[cmd.lane]);
	assign stretch   = root_q - {3'd0, rest_q};
	assign lower_cnt = (cnt_q == CNT_TOP) ? '0 : cnt_q + 1'b1;
	assign cnt_ext   = {6'd0, cnt_q};
	assign low_ext   = {6'd0, lower_cnt};

	assign sq_rn    = {rem_q, rad_q[67:66]};
	assign sq_trial = {2'd0, root_q, 2'b01};
	assign sq_diff  = sq_rn - sq_trial;

	assign ten_sum = {1'b0, ten_q} + {1'b0, trcf_pkg::sat_q16(p_q)};
	assign ten_sat = (ten_sum > {1'b0, trcf_pkg::TMAX}) ? trcf_pkg::TMAX : ten_sum[30:0];
	assign rt_term = {2'd0, p_q[63:30]};
	assign f_mag   = p_q[61:30];

	// one shared multiplier, operands picked by the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			trcf_pkg::OP_MSQ: begin
				mul_a = d_mag;
				mul_b = {2'd0, d_mag};
			end
			trcf_pkg::OP_MRT: begin
				mul_a = {2'd0, quo_q[cmd.lane]};
				mul_b = {2'd0, dv_mag};
			end
			trcf_pkg::OP_MK: begin
				mul_a = {1'b0, stiff_q};
				mul_b = {1'b0, stretch};
			end
			trcf_pkg::OP_MC: begin
				mul_a = {1'b0, damp_q};
				mul_b = (rate_q > 36'sd0) ? rate_q[34:0] : 35'd0;
			end
			trcf_pkg::OP_MF: begin
				mul_a = {2'd0, ten_q};
				mul_b = {4'd0, quo_q[cmd.lane]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q     <= 32'd0;
			damp_q      <= 32'd0;
			rest_q      <= 31'd65536;
			mind_q      <= 31'd66;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					trcf_pkg::REG_STIFFNESS:    stiff_q <= cfg_data;
					trcf_pkg::REG_DAMPING:      damp_q  <= cfg_data;
					trcf_pkg::REG_REST_LENGTH:  rest_q  <= cfg_data[30:0];
					trcf_pkg::REG_MIN_DISTANCE: mind_q  <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
			case (cmd.op)
				trcf_pkg::OP_FIRST: begin
					if (!last_q) begin
						have_prev_q <= 1'b1;
						cnt_q       <= '0;
					end
				end
				trcf_pkg::OP_OUT1: begin
					if (!last_q)
						cnt_q <= lower_cnt;
				end
				trcf_pkg::OP_OUT2: begin
					have_prev_q <= 1'b0;
					cnt_q       <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == trcf_pkg::OP_MSQ || cmd.op == trcf_pkg::OP_MRT
				|| cmd.op == trcf_pkg::OP_MK || cmd.op == trcf_pkg::OP_MC
				|| cmd.op == trcf_pkg::OP_MF)
			p_q <= {35'd0, mul_a} * {33'd0, mul_b};
		case (cmd.op)
			trcf_pkg::OP_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					pos_q[i] <= in_pos[i];
					vel_q[i] <= in_vel[i];
					d_q[i]   <= {prev_pos_q[i][31], prev_pos_q[i]} - {in_pos[i][31], in_pos[i]};
					dv_q[i]  <= {prev_vel_q[i][31], prev_vel_q[i]} - {in_vel[i][31], in_vel[i]};
				end
				last_q  <= last_node;
				sumsq_q <= '0;
				rate_q  <= '0;
			end
			trcf_pkg::OP_FIRST: begin
				if (last_q) begin
					force_x         <= '0;
					force_y         <= '0;
					force_z         <= '0;
					segment_tension <= '0;
					node_index      <= '0;
					chain_done      <= 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						prev_pos_q[i] <= pos_q[i];
						prev_vel_q[i] <= vel_q[i];
						carried_q[i]  <= '0;
					end
				end
			end
			trcf_pkg::OP_ASQ: begin
				sumsq_q <= sumsq_q + p_q[65:0];
			end
			trcf_pkg::OP_SQI: begin
				rad_q  <= {2'd0, sumsq_q};
				root_q <= '0;
				rem_q  <= '0;
			end
			trcf_pkg::OP_SQS: begin
				rad_q <= {rad_q[65:0], 2'b00};
				if (sq_rn >= sq_trial) begin
					rem_q  <= sq_diff[35:0];
					root_q <= {root_q[32:0], 1'b1};
				end else begin
					rem_q  <= sq_rn[35:0];
					root_q <= {root_q[32:0], 1'b0};
				end
			end
			trcf_pkg::OP_DVI: begin
				act_q <= (root_q >= {3'd0, mind_q}) && (root_q > {3'd0, rest_q});
				for (int i = 0; i < 3; i++) begin
					dr_q[i]  <= {2'd0, trcf_pkg::mag33(d_q[i]) >> 1};
					nb_q[i]  <= d_q[i][0];
					quo_q[i] <= '0;
				end
			end
			trcf_pkg::OP_DVS: begin
				// restoring divide, all three lanes in step
				for (int i = 0; i < 3; i++) begin
					if ({dr_q[i], nb_q[i]} >= {2'd0, root_q}) begin
						dr_q[i]  <= 35'({dr_q[i], nb_q[i]} - {2'd0, root_q});
						quo_q[i] <= {quo_q[i][29:0], 1'b1};
					end else begin
						dr_q[i]  <= {dr_q[i][33:0], nb_q[i]};
						quo_q[i] <= {quo_q[i][29:0], 1'b0};
					end
					nb_q[i] <= 1'b0;
				end
			end
			trcf_pkg::OP_MRT: begin
				sg_q <= d_q[cmd.lane][32] ^ dv_q[cmd.lane][32];
			end
			trcf_pkg::OP_ART: begin
				rate_q <= sg_q ? (rate_q - $signed(rt_term)) : (rate_q + $signed(rt_term));
			end
			trcf_pkg::OP_AK: begin
				ten_q <= trcf_pkg::sat_q16(p_q);
			end
			trcf_pkg::OP_AC: begin
				ten_q <= act_q ? ten_sat : 31'd0;
			end
			trcf_pkg::OP_MF: begin
				sg_q <= d_q[cmd.lane][32];
			end
			trcf_pkg::OP_AF: begin
				f_q[cmd.lane] <= sg_q ? (32'd0 - f_mag) : f_mag;
			end
			trcf_pkg::OP_OUT1: begin
				force_x <= trcf_pkg::sat32({carried_q[0][31], carried_q[0]} - {f_q[0][31], f_q[0]});
				force_y <= trcf_pkg::sat32({carried_q[1][31], carried_q[1]} - {f_q[1][31], f_q[1]});
				force_z <= trcf_pkg::sat32({carried_q[2][31], carried_q[2]} - {f_q[2][31], f_q[2]});
				segment_tension <= ten_q;
				node_index      <= cnt_ext[5:0];
				chain_done      <= 1'b0;
				if (!last_q) begin
					for (int i = 0; i < 3; i++) begin
						prev_pos_q[i] <= pos_q[i];
						prev_vel_q[i] <= vel_q[i];
						carried_q[i]  <= f_q[i];
					end
				end
			end
			trcf_pkg::OP_OUT2: begin
				force_x         <= f_q[0];
				force_y         <= f_q[1];
				force_z         <= f_q[2];
				segment_tension <= '0;
				node_index      <= low_ext[5:0];
				chain_done      <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/tension_only_rope_chain_force_core.sv]
// Top level of the tension-only rope chain force core.
//
//  channel   direction  handshake           payload
//  in        sink       in_valid/in_stall   pos_*, vel_*, last_node
//  out       source     out_valid/out_stall force_*, segment_tension, node_index, chain_done
//  cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item with a node above it runs 34 square root steps and 31 divider steps, plus
// 22 multiply and accumulate steps on the shared multiplier and its load, setup and
// result steps. A chain's first node runs only its load and first-node steps. The
// last node of a chain of more than one node issues two results.
// Reset clears the sequencer and the chain state and sets the config registers to their defaults.
// A stalled result holds in the output register; the next item is still taken and
// waits only at its own result. A last node's second result waits behind the first.
module tension_only_rope_chain_force_core #(
	parameter int MAX_NODES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic signed [31:0]  vel_z,
	input  logic                last_node,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  force_x,
	output logic signed [31:0]  force_y,
	output logic signed [31:0]  force_z,
	output logic [30:0]         segment_tension,
	output logic [5:0]          node_index,
	output logic                chain_done,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	trcf_pkg::cmd_t cmd;
	trcf_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	trcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	trcf_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.sts             (sts),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.vel_x           (vel_x),
		.vel_y           (vel_y),
		.vel_z           (vel_z),
		.last_node       (last_node),
		.force_x         (force_x),
		.force_y         (force_y),
		.force_z         (force_z),
		.segment_tension (segment_tension),
		.node_index      (node_index),
		.chain_done      (chain_done)
	);

endmodule

[rtl/core/trcf_chk.sv]
// Port-level checks for the rope chain force core, bound to the top level.
module trcf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] force_x,
	input logic [30:0] segment_tension,
	input logic        chain_done
);

	// one transaction at a time: busy right after taking one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(force_x))
		else $error("stalled result changed");

	a_last_no_tension: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chain_done |-> segment_tension == 31'd0)
		else $error("final node reports a segment tension");

endmodule

bind tension_only_rope_chain_force_core trcf_chk u_trcf_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.force_x         (force_x),
	.segment_tension (segment_tension),
	.chain_done      (chain_done)
);
